/* rtl/accel_impact_detector_assert.svh */
// Assertion macros used by the impact detector checker.
`ifndef ACCEL_IMPACT_DETECTOR_ASSERT_SVH
`define ACCEL_IMPACT_DETECTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while reset is asserted.
`define AID_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, quiet while reset is asserted.
`define AID_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/aid_pkg.sv */
// Shared widths, register codes and lane control type of the impact detector.
`default_nettype none
package aid_pkg;
	localparam int SAMPLE_BITS    = 32;
	localparam int CAL_COUNT_BITS = 12;

	localparam int ACCEL_BITS  = 32;
	localparam int TIME_BITS   = 32;
	localparam int THRESH_BITS = 24;
	localparam int COOL_BITS   = 32;
	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_INDEX_BITS = 2;
	localparam int DEV_BITS    = 24;
	localparam int MAG_BITS    = 24;
	localparam int TOTAL_BITS  = 32;
	localparam int IN_BITS     = 3 * ACCEL_BITS + TIME_BITS;
	localparam int OUT_BITS    = 3 * DEV_BITS + MAG_BITS + TOTAL_BITS;
	localparam int USER_BITS   = 2;

	localparam int SUM_BITS    = SAMPLE_BITS + CAL_COUNT_BITS;
	localparam int CNT_BITS    = CAL_COUNT_BITS + 1;
	localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);
	localparam int DIFF_BITS   = SAMPLE_BITS + 1;
	localparam int CMP_BITS    = (DIFF_BITS > DEV_BITS) ? DIFF_BITS : DEV_BITS + 1;
	localparam int SQ_BITS     = 2 * DEV_BITS;
	localparam int ROOT_BITS   = (SQ_BITS + 2) / 2;
	localparam int RAD_BITS    = 2 * ROOT_BITS;
	localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS);

	localparam int DEV_MAX = 8388607;
	localparam int DEV_MIN = -8388608;
	localparam logic signed [CMP_BITS-1:0] SAT_HI = CMP_BITS'(DEV_MAX);
	localparam logic signed [CMP_BITS-1:0] SAT_LO = CMP_BITS'(DEV_MIN);

	localparam logic [THRESH_BITS-1:0]    THRESH_RESET = THRESH_BITS'(3277);
	localparam logic [COOL_BITS-1:0]      COOL_RESET   = COOL_BITS'(350000);
	localparam logic [CAL_COUNT_BITS-1:0] CAL_RESET    = CAL_COUNT_BITS'(200);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_THRESHOLD   = 2'd0,
		CFG_COOLDOWN    = 2'd1,
		CFG_CAL_SAMPLES = 2'd2
	} cfg_index_t;

	// Per-cycle commands from the sequencer to the axis lanes.
	typedef struct packed {
		logic                load;
		logic                accum;
		logic                div_start;
		logic                div_step;
		logic                div_load;
		logic                dev_en;
		logic                sq_en;
		logic [CNT_BITS-1:0] divisor;
	} lane_ctrl_t;
endpackage
`default_nettype wire

/* rtl/aid_lane.sv */
// One axis lane: calibration sum, baseline divider, saturated deviation and its square.
`default_nettype none
module aid_lane (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire aid_pkg::lane_ctrl_t           ctrl,
	input  wire logic [aid_pkg::ACCEL_BITS-1:0] sample,
	output logic      [aid_pkg::DEV_BITS-1:0]  dev,
	output logic      [aid_pkg::SQ_BITS-1:0]   sq
);
	import aid_pkg::*;

	logic        [SAMPLE_BITS-1:0]    sample_q;
	logic signed [SUM_BITS-1:0]       cal_sum_q;
	logic        [SAMPLE_BITS-1:0]    baseline_q;
	logic        [SUM_BITS-1:0]       quo_q;
	logic        [CAL_COUNT_BITS-1:0] rem_q;
	logic                             neg_q;
	logic signed [DEV_BITS-1:0]       dev_s1;
	logic        [DEV_BITS-1:0]       abs_s1;
	logic        [SQ_BITS-1:0]        sq_s2;

	logic signed [SUM_BITS-1:0]  sample_ext;
	logic        [SUM_BITS-1:0]  sum_abs;
	logic        [CNT_BITS-1:0]  trial;
	logic                        trial_ge;
	logic        [CNT_BITS-1:0]  trial_sub;
	logic        [SAMPLE_BITS-1:0] quo_lo;
	logic signed [DIFF_BITS-1:0] diff;
	logic signed [CMP_BITS-1:0]  diff_w;
	logic signed [CMP_BITS-1:0]  sat_w;
	logic signed [DEV_BITS-1:0]  sat;
	logic        [DEV_BITS-1:0]  sat_abs;

	assign sample_ext = {{(SUM_BITS - SAMPLE_BITS){sample[SAMPLE_BITS-1]}},
		sample[SAMPLE_BITS-1:0]};
	assign sum_abs    = cal_sum_q[SUM_BITS-1] ? SUM_BITS'(-cal_sum_q) : cal_sum_q;

	// restoring divide of |sum| by the sample count, one quotient bit a cycle
	assign trial     = {rem_q, quo_q[SUM_BITS-1]};
	assign trial_ge  = trial >= ctrl.divisor;
	assign trial_sub = trial - ctrl.divisor;
	assign quo_lo    = quo_q[SAMPLE_BITS-1:0];

	assign diff   = $signed({sample_q[SAMPLE_BITS-1], sample_q})
		- $signed({baseline_q[SAMPLE_BITS-1], baseline_q});
	assign diff_w = CMP_BITS'(diff);

	always_comb begin
		if (diff_w > SAT_HI) begin
			sat_w = SAT_HI;
		end else if (diff_w < SAT_LO) begin
			sat_w = SAT_LO;
		end else begin
			sat_w = diff_w;
		end
	end

	assign sat     = sat_w[DEV_BITS-1:0];
	assign sat_abs = sat[DEV_BITS-1] ? DEV_BITS'(-sat) : sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_sum_q  <= '0;
			baseline_q <= '0;
		end else begin
			if (ctrl.accum) begin
				cal_sum_q <= cal_sum_q + sample_ext;
			end
			if (ctrl.div_load) begin
				baseline_q <= neg_q ? SAMPLE_BITS'(-quo_lo) : quo_lo;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sample_q <= sample[SAMPLE_BITS-1:0];
		end
		if (ctrl.div_start) begin
			quo_q <= sum_abs;
			rem_q <= '0;
			neg_q <= cal_sum_q[SUM_BITS-1];
		end else if (ctrl.div_step) begin
			quo_q <= {quo_q[SUM_BITS-2:0], trial_ge};
			rem_q <= trial_ge ? trial_sub[CAL_COUNT_BITS-1:0] : trial[CAL_COUNT_BITS-1:0];
		end
		if (ctrl.dev_en) begin
			dev_s1 <= sat;
			abs_s1 <= sat_abs;
		end
		if (ctrl.sq_en) begin
			sq_s2 <= abs_s1 * abs_s1;
		end
	end

	assign dev = dev_s1;
	assign sq  = sq_s2;
endmodule
`default_nettype wire

/* rtl/aid_isqrt.sv */
// Iterative floor square root, one root bit per cycle.
`default_nettype none
module aid_isqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [aid_pkg::RAD_BITS-1:0]  radicand,
	output logic                               done,
	output logic      [aid_pkg::ROOT_BITS-1:0] root
);
	import aid_pkg::*;

	localparam int REM_BITS = ROOT_BITS + 2;

	logic                     busy_q;
	logic [ROOT_CNT_BITS-1:0] cnt_q;
	logic [RAD_BITS-1:0]      rad_q;
	logic [REM_BITS-1:0]      rem_q;
	logic [ROOT_BITS-1:0]     root_q;

	logic [REM_BITS+1:0] cand;
	logic [REM_BITS+1:0] trial;
	logic                fits;
	logic [REM_BITS+1:0] cand_sub;

	assign cand     = {rem_q, rad_q[RAD_BITS-1 -: 2]};
	assign trial    = (REM_BITS + 2)'({root_q, 2'b01});
	assign fits     = cand >= trial;
	assign cand_sub = cand - trial;
	assign done     = busy_q && (cnt_q == ROOT_CNT_BITS'(ROOT_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= !done;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			// bring down two bits, keep the trial difference if it fits
			rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
			rem_q  <= fits ? cand_sub[REM_BITS-1:0] : cand[REM_BITS-1:0];
			root_q <= {root_q[ROOT_BITS-2:0], fits};
		end
	end

	assign root = root_q;
endmodule
`default_nettype wire

/* rtl/accel_impact_detector.sv */
// Order of work: a calibrating sample goes from accept through the FIN state to the output,
// the one that closes calibration first runs the baseline divider (one baseline quotient
// bit per cycle), and a tracked sample runs deviation, square, sum, then one root bit per cycle over 25 steps.
// One sample is in flight at a time: a new beat is taken only once the last result is in
// the output register, later while the previous result beat waits for m_tready.
// arst_n clears the sequencer, calibration, counters and the output valid, and loads
// the register defaults.
`default_nettype none
module accel_impact_detector (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [aid_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [aid_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// accel_x, accel_y, accel_z, time_now
	input  wire logic [aid_pkg::IN_BITS-1:0]        s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// dev_x, dev_y, dev_z, magnitude, impact_total
	output logic      [aid_pkg::OUT_BITS-1:0]       m_tdata,
	// calibrating, impact
	output logic      [aid_pkg::USER_BITS-1:0]      m_tuser
);
	import aid_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_INIT,
		ST_DIV,
		ST_DIV_END,
		ST_DEV,
		ST_SQ,
		ST_SUM,
		ST_ROOT,
		ST_FIN
	} state_t;

	state_t                    state_q;
	logic [THRESH_BITS-1:0]    threshold_q;
	logic [COOL_BITS-1:0]      cooldown_q;
	logic [CAL_COUNT_BITS-1:0] cal_samples_q;
	logic [CAL_COUNT_BITS-1:0] cal_seen_q;
	logic                      cal_closed_q;
	logic                      cal_item_q;
	logic [CNT_BITS-1:0]       cnt_q;
	logic [DIV_CNT_BITS-1:0]   div_cnt_q;
	logic [TIME_BITS-1:0]      time_q;
	logic [TOTAL_BITS-1:0]     impact_cnt_q;
	logic [TIME_BITS-1:0]      last_stamp_q;
	logic                      any_hit_q;
	logic                      m_tvalid_q;
	logic [OUT_BITS-1:0]       m_tdata_q;
	logic [USER_BITS-1:0]      m_tuser_q;

	lane_ctrl_t                ctrl;
	logic                      s_accept;
	logic                      out_free;
	logic [CAL_COUNT_BITS-1:0] seen_next;
	logic                      cal_close;
	logic [DEV_BITS-1:0]       dev [3];
	logic [SQ_BITS-1:0]        sq [3];
	logic [RAD_BITS-1:0]       sum_sq;
	logic                      root_done;
	logic [ROOT_BITS-1:0]      root;
	logic [MAG_BITS-1:0]       mag;
	logic [TIME_BITS-1:0]      elapsed;
	logic                      hit;
	logic [TOTAL_BITS-1:0]     total_next;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign seen_next = cal_seen_q + 1'b1;
	// a zero count closes at once; a wrapped count means the full range was seen
	assign cal_close = (seen_next >= cal_samples_q) || (seen_next == '0);

	always_comb begin
		ctrl           = '0;
		ctrl.load      = s_accept;
		ctrl.accum     = s_accept && !cal_closed_q;
		ctrl.div_start = (state_q == ST_DIV_INIT);
		ctrl.div_step  = (state_q == ST_DIV);
		ctrl.div_load  = (state_q == ST_DIV_END);
		ctrl.dev_en    = (state_q == ST_DEV);
		ctrl.sq_en     = (state_q == ST_SQ);
		ctrl.divisor   = cnt_q;
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		aid_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.sample (s_tdata[g*ACCEL_BITS +: ACCEL_BITS]),
			.dev    (dev[g]),
			.sq     (sq[g])
		);
	end

	// merge the three lanes: sum of squares, then the shared root unit
	assign sum_sq = RAD_BITS'(sq[0]) + RAD_BITS'(sq[1]) + RAD_BITS'(sq[2]);

	aid_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_SUM),
		.radicand (sum_sq),
		.done     (root_done),
		.root     (root)
	);

	assign mag        = root[MAG_BITS-1:0];
	assign elapsed    = time_q - last_stamp_q;
	assign hit        = (mag > threshold_q) && (!any_hit_q || (elapsed > cooldown_q));
	assign total_next = impact_cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			threshold_q   <= THRESH_RESET;
			cooldown_q    <= COOL_RESET;
			cal_samples_q <= CAL_RESET;
			cal_seen_q    <= '0;
			cal_closed_q  <= 1'b0;
			cal_item_q    <= 1'b0;
			cnt_q         <= '0;
			div_cnt_q     <= '0;
			time_q        <= '0;
			impact_cnt_q  <= '0;
			last_stamp_q  <= '0;
			any_hit_q     <= 1'b0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
			m_tuser_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_THRESHOLD:   threshold_q   <= cfg_data[THRESH_BITS-1:0];
					CFG_COOLDOWN:    cooldown_q    <= cfg_data[COOL_BITS-1:0];
					CFG_CAL_SAMPLES: cal_samples_q <= cfg_data[CAL_COUNT_BITS-1:0];
					default: ;
				endcase
			end

			// drop the valid after its beat unless a new result replaces it
			if (m_tvalid_q && m_tready && (state_q != ST_FIN)) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						time_q <= s_tdata[3*ACCEL_BITS +: TIME_BITS];
						if (!cal_closed_q) begin
							cal_item_q <= 1'b1;
							cal_seen_q <= seen_next;
							if (cal_close) begin
								cal_closed_q <= 1'b1;
								cnt_q      <= (seen_next == '0) ? CNT_BITS'(1 << CAL_COUNT_BITS)
									: CNT_BITS'(seen_next);
								state_q    <= ST_DIV_INIT;
							end else begin
								state_q <= ST_FIN;
							end
						end else begin
							cal_item_q <= 1'b0;
							state_q    <= ST_DEV;
						end
					end
				end
				ST_DIV_INIT: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_BITS'(SUM_BITS - 1)) begin
						state_q <= ST_DIV_END;
					end
				end
				ST_DIV_END: state_q <= ST_FIN;
				ST_DEV:     state_q <= ST_SQ;
				ST_SQ:      state_q <= ST_SUM;
				ST_SUM:     state_q <= ST_ROOT;
				ST_ROOT: begin
					if (root_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (cal_item_q) begin
							m_tdata_q <= {impact_cnt_q, (OUT_BITS - TOTAL_BITS)'(0)};
							m_tuser_q <= 2'b01;
						end else begin
							m_tdata_q <= {hit ? total_next : impact_cnt_q, mag,
								dev[2], dev[1], dev[0]};
							m_tuser_q <= {hit, 1'b0};
							if (hit) begin
								impact_cnt_q <= total_next;
								last_stamp_q <= time_q;
								any_hit_q    <= 1'b1;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
endmodule
`default_nettype wire

/* rtl/aid_checker.sv */
// Port-level checker for the impact detector and its bind.
`default_nettype none
`include "accel_impact_detector_assert.svh"
module aid_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_tvalid,
	input wire logic                               s_tready,
	input wire logic                               m_tvalid,
	input wire logic                               m_tready,
	input wire logic [aid_pkg::OUT_BITS-1:0]       m_tdata,
	input wire logic [aid_pkg::USER_BITS-1:0]      m_tuser
);
	import aid_pkg::*;

	localparam int FIELD_BITS = OUT_BITS - TOTAL_BITS;

	// one sample in flight: input closes right after a beat
	`AID_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
	// stalled result beat holds
	`AID_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// calibration beats carry no deviation, magnitude or impact
	`AID_ASSERT_IMP(a_cal_zero, m_tvalid && m_tuser[0], (m_tdata[FIELD_BITS-1:0] == '0) && !m_tuser[1])
	// an impact beat must show a nonzero magnitude
	`AID_ASSERT_IMP(a_hit_mag, m_tvalid && m_tuser[1], m_tdata[FIELD_BITS-1 -: MAG_BITS] != '0)
endmodule

bind accel_impact_detector aid_checker u_aid_checker (.*);
`default_nettype wire

/* test/accel_impact_detector_tb.sv */
// Self-checking testbench of the accelerometer impact detector: directed and random samples.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import aid_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PRINT_LIMIT = 50;

	typedef struct packed {
		logic                   calibrating;
		logic [DEV_BITS-1:0]    dev_x;
		logic [DEV_BITS-1:0]    dev_y;
		logic [DEV_BITS-1:0]    dev_z;
		logic [MAG_BITS-1:0]    magnitude;
		logic                   impact;
		logic [TOTAL_BITS-1:0]  impact_total;
	} reading_t;

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      cfg_we    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_THRESHOLD;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
	logic                      s_tvalid  = 1'b0;
	logic                      s_tready;
	// accel_x, accel_y, accel_z, time_now
	logic [IN_BITS-1:0]        s_tdata   = '0;
	logic                      m_tvalid;
	logic                      m_tready  = 1'b0;
	// dev_x, dev_y, dev_z, magnitude, impact_total
	logic [OUT_BITS-1:0]       m_tdata;
	// calibrating, impact
	logic [USER_BITS-1:0]      m_tuser;

	// shadow of the detector state and registers
	logic [THRESH_BITS-1:0]    thresh_reg = THRESH_RESET;
	logic [COOL_BITS-1:0]      cool_reg   = COOL_RESET;
	logic [CAL_COUNT_BITS-1:0] cal_len    = CAL_RESET;
	longint                    cal_acc [3] = '{0, 0, 0};
	logic [CAL_COUNT_BITS-1:0] cal_seen_n = '0;
	logic                      cal_closed = 1'b0;
	longint                    base [3]   = '{0, 0, 0};
	logic [TOTAL_BITS-1:0]     hits       = '0;
	logic [TIME_BITS-1:0]      last_hit_stamp = '0;
	logic                      hit_seen   = 1'b0;

	reading_t readings_due [$];
	reading_t want_beat;
	int       mismatches    = 0;
	int       readings_seen = 0;
	int       cycle_count   = 0;
	bit       gap_en        = 1'b1;
	bit       stall_en      = 1'b1;
	logic [TIME_BITS-1:0] tnow_rand = '0;

	accel_impact_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic reading_t predict_reading(logic [31:0] ax, logic [31:0] ay,
			logic [31:0] az, logic [31:0] tnow);
		reading_t             r;
		longint               s [3];
		longint               d;
		logic [DEV_BITS-1:0]  dev [3];
		longint unsigned      a, sq, root, bitv;
		logic [TIME_BITS-1:0] elapsed;
		int                   cnt;
		r = '0;
		s[0] = longint'(signed'(ax));
		s[1] = longint'(signed'(ay));
		s[2] = longint'(signed'(az));
		if (!cal_closed) begin
			for (int i = 0; i < 3; i++) cal_acc[i] += s[i];
			cal_seen_n = cal_seen_n + 1'b1;
			if (cal_seen_n >= cal_len || cal_seen_n == 0) begin
				cnt = (cal_seen_n == 0) ? (1 << CAL_COUNT_BITS) : int'(cal_seen_n);
				for (int i = 0; i < 3; i++) base[i] = cal_acc[i] / longint'(cnt);
				cal_closed = 1'b1;
			end
			r.calibrating  = 1'b1;
			r.impact_total = hits;
			return r;
		end
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			d = s[i] - base[i];
			if (d > DEV_MAX) d = DEV_MAX;
			if (d < DEV_MIN) d = DEV_MIN;
			dev[i] = d[DEV_BITS-1:0];
			a = (d < 0) ? -d : d;
			sq += a * a;
		end
		// bitwise floor square root
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > sq) bitv >>= 2;
		while (bitv != 0) begin
			if (sq >= root + bitv) begin
				sq -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		elapsed = tnow - last_hit_stamp;
		if (root > thresh_reg && (!hit_seen || elapsed > cool_reg)) begin
			hits = hits + 1'b1;
			last_hit_stamp = tnow;
			hit_seen = 1'b1;
			r.impact = 1'b1;
		end
		r.dev_x        = dev[0];
		r.dev_y        = dev[1];
		r.dev_z        = dev[2];
		r.magnitude    = root[MAG_BITS-1:0];
		r.impact_total = hits;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch on %s at reading %0d: got %h, want %h", what, readings_seen,
				got, want);
	endtask

	task automatic send_sample(input logic [31:0] ax, input logic [31:0] ay,
			input logic [31:0] az, input logic [31:0] tnow);
		if (gap_en && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {tnow, az, ay, ax};
		do @(posedge clk); while (!s_tready);
		readings_due.push_back(predict_reading(ax, ay, az, tnow));
	endtask

	// Drain every outstanding reading, then write one register.
	task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
		s_tvalid <= 1'b0;
		while (readings_due.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_THRESHOLD: begin
				thresh_reg = val[THRESH_BITS-1:0];
			end
			CFG_COOLDOWN: begin
				cool_reg = val[COOL_BITS-1:0];
			end
			CFG_CAL_SAMPLES: begin
				cal_len = val[CAL_COUNT_BITS-1:0];
			end
			default: begin
			end
		endcase
	endtask

	// Start with the largest count, then drop it to zero so the next sample closes the average.
	task automatic test_calibration();
		write_reg(CFG_CAL_SAMPLES, 32'd4095);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0000_0000);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0001, 32'hFFFF_FFFF);
		send_sample(32'h0000_0064, 32'hFFFF_FF00, 32'h0000_FFFF, 32'h0000_0000);
		send_sample(32'hFFFF_FFFD, 32'h0000_0005, 32'h0001_0004, 32'hFFFF_FFFF);
		send_sample(32'h0000_0007, 32'hFFFF_FFF1, 32'h0000_FFFA, 32'h1234_5678);
		write_reg(CFG_CAL_SAMPLES, 32'd0);
		send_sample(32'hFFFF_FFFF, 32'h0000_0004, 32'h0001_0005, 32'h0000_0010);
	endtask

	// Threshold and cooldown straight out of reset; the first impact ignores the cooldown.
	task automatic test_default_thresholds();
		send_sample(32'(base[0]), 32'(base[1]), 32'(base[2]), 32'd1000);
		send_sample(32'(base[0] + 3277), 32'(base[1]), 32'(base[2]), 32'd2000);
		send_sample(32'(base[0] + 3278), 32'(base[1]), 32'(base[2]), 32'd3000);
		send_sample(32'(base[0]), 32'(base[1] - 5000), 32'(base[2]), 32'd353000);
		send_sample(32'(base[0]), 32'(base[1]), 32'(base[2] + 5000), 32'd353001);
		send_sample(32'(base[0] + 3000), 32'(base[1] - 4000), 32'(base[2]), 32'd353006);
		send_sample(32'(base[0] + 1), 32'(base[1] + 1), 32'(base[2] + 1), 32'd353010);
	endtask

	task automatic test_saturation();
		write_reg(CFG_THRESHOLD, 32'h00FF_FFFF);
		send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
		send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
		send_sample(32'(base[0] + 8388607), 32'(base[1] - 8388608), 32'(base[2] + 8388608),
			32'h5555_5555);
		send_sample(32'(base[0] - 8388609), 32'(base[1] + 8388609), 32'(base[2] - 8388607),
			32'hAAAA_AAAA);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'(base[2]), 32'h0000_0001);
	endtask

	task automatic test_cooldown_wrap();
		write_reg(CFG_THRESHOLD, 32'd0);
		write_reg(CFG_COOLDOWN, 32'd100);
		send_sample(32'(base[0] + 1), 32'(base[1]), 32'(base[2]), 32'hFFFF_FFF0);
		send_sample(32'(base[0] + 1), 32'(base[1]), 32'(base[2]), 32'h0000_0050);
		send_sample(32'(base[0] + 1), 32'(base[1]), 32'(base[2]), 32'h0000_0054);
		send_sample(32'(base[0] + 1), 32'(base[1]), 32'(base[2]), 32'h0000_0055);
		send_sample(32'(base[0]), 32'(base[1]), 32'(base[2]), 32'h0000_1000);
		write_reg(CFG_COOLDOWN, 32'd0);
		send_sample(32'(base[0]), 32'(base[1] - 1), 32'(base[2]), 32'h0000_0055);
		send_sample(32'(base[0]), 32'(base[1] - 1), 32'(base[2]), 32'h0000_0056);
		write_reg(CFG_COOLDOWN, 32'hFFFF_FFFF);
		send_sample(32'(base[0]), 32'(base[1]), 32'(base[2] + 1), 32'h0000_0055);
	endtask

	task automatic run_random_phase(input int n, input bit idle, input logic [31:0] thr,
			input logic [31:0] cool, input int span);
		int          kind;
		int          k;
		longint      off;
		logic [31:0] v [3];
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_COOLDOWN, cool);
		write_reg(CFG_CAL_SAMPLES, $urandom_range(0, 4095));
		gap_en   = idle;
		stall_en = idle;
		repeat (n) begin
			kind = $urandom_range(99);
			if (kind < 10) tnow_rand = $urandom;
			else if (kind >= 20) tnow_rand = tnow_rand + $urandom_range(0, span);
			kind = $urandom_range(99);
			for (int i = 0; i < 3; i++) begin
				if (kind < 60) begin
					k   = $urandom_range(0, 15);
					off = $urandom_range(0, 1 << k);
					if ($urandom_range(1)) off = -off;
					v[i] = 32'(base[i] + off);
				end else if (kind < 75) begin
					v[i] = $urandom;
				end else if (kind < 90) begin
					// straddle the edge of the deviation range
					off = 8388600 + $urandom_range(0, 16);
					if ($urandom_range(1)) off = -off;
					v[i] = 32'(base[i] + off);
				end else begin
					case ($urandom_range(3))
						0: v[i] = 32'h7FFF_FFFF;
						1: v[i] = 32'h8000_0000;
						2: v[i] = 32'h0000_0000;
						default: v[i] = 32'hFFFF_FFFF;
					endcase
				end
			end
			send_sample(v[0], v[1], v[2], tnow_rand);
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(110, 1'b1, $urandom_range(0, 20000), 32'd0, 50);
		run_random_phase(110, 1'b1, $urandom_range(0, 20000), $urandom_range(0, 2000), 400);
		// stretch with no input gaps and the output always ready
		run_random_phase(110, 1'b0, $urandom_range(0, 20000), 32'd350000, 120000);
		run_random_phase(110, 1'b1, $urandom_range(0, 20000), 32'hFFFF_FFFF, 1000);
		run_random_phase(110, 1'b1, $urandom_range(0, 24'hFF_FFFF), $urandom, 0);
		run_random_phase(100, 1'b1, 32'd0, $urandom_range(0, 100), 64);
	endtask

	// Check each output beat against the oldest prediction; stall the output at random.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			if (arst_n && m_tvalid && m_tready) begin
				if (readings_due.size() == 0) begin
					report("unexpected beat", m_tdata[31:0], '0);
				end else begin
					want_beat = readings_due.pop_front();
					if (m_tuser[0] !== want_beat.calibrating)
						report("calibrating", 32'(m_tuser[0]), 32'(want_beat.calibrating));
					if (m_tdata[23:0] !== want_beat.dev_x)
						report("dev_x", 32'(m_tdata[23:0]), 32'(want_beat.dev_x));
					if (m_tdata[47:24] !== want_beat.dev_y)
						report("dev_y", 32'(m_tdata[47:24]), 32'(want_beat.dev_y));
					if (m_tdata[71:48] !== want_beat.dev_z)
						report("dev_z", 32'(m_tdata[71:48]), 32'(want_beat.dev_z));
					if (m_tdata[95:72] !== want_beat.magnitude)
						report("magnitude", 32'(m_tdata[95:72]), 32'(want_beat.magnitude));
					if (m_tuser[1] !== want_beat.impact)
						report("impact", 32'(m_tuser[1]), 32'(want_beat.impact));
					if (m_tdata[127:96] !== want_beat.impact_total)
						report("impact_total", m_tdata[127:96], want_beat.impact_total);
				end
				readings_seen++;
			end
			m_tready <= stall_en ? ($urandom_range(99) >= 6) : 1'b1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_calibration();
		test_default_thresholds();
		test_saturation();
		test_cooldown_wrap();
		test_random_traffic();
		s_tvalid <= 1'b0;
		while (readings_due.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

/* accel_impact_detector.f */
+incdir+rtl
rtl/aid_pkg.sv
rtl/aid_lane.sv
rtl/aid_isqrt.sv
rtl/accel_impact_detector.sv
rtl/aid_checker.sv
test/accel_impact_detector_tb.sv
